// ===== rtl/yrpi_pkg.sv =====
`timescale 1ns / 1ps
package yrpi_pkg;

    // Profile quarter length in ticks
    localparam int QUARTER_TICKS_DEF = 40;

    // Port field widths
    localparam int RATE_W       = 16;
    localparam int SPEED_W      = 15;
    localparam int TARGET_OUT_W = 15;
    localparam int HEAD_W       = 17;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 64;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int BASE_W     = 14;
    localparam int GAIN_W     = 12;
    localparam int ILIM_W     = 15;
    localparam int DLIM_W     = 13;
    localparam int STEP_W     = 8;

    localparam logic [BASE_W-1:0] CRUISE_SPEED_RST   = 14'd500;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST      = 12'd512;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST     = 12'd256;
    localparam logic [ILIM_W-1:0] INTEGRAL_LIMIT_RST = 15'd20480;
    localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST    = 13'd180;
    localparam logic [STEP_W-1:0] PROFILE_STEP_RST   = 8'd32;

    // Internal datapath widths
    localparam int TARGET_W = 16;
    localparam int ERR_W    = 18;
    localparam int SCALED_W = 18;
    localparam int INTEG_W  = 17;
    localparam int ISUM_W   = 19;
    localparam int YAW_W    = 17;
    localparam int MUL_W    = 22;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 36;
    localparam int QUO_W    = ACC_W - 16;
    localparam int DIFF_W   = 14;
    localparam int SUM_W    = 16;

    // round(v*4/5) = floor((4v+2)/5); offset keeps the dividend positive,
    // then floor(x/5) = (x * ceil(2^23/5)) >> 23, exact for x < 2^22.
    localparam int                 SCALE_SHIFT  = 23;
    localparam int                 SCALE_QUOT_W = 19;
    localparam logic signed [MUL_W-1:0] SCALE_RECIP  = 22'sd1677722;
    localparam logic signed [MUL_W-1:0] SCALE_OFFSET = 22'sd1310720;
    localparam logic signed [MUL_W-1:0] SCALE_ROUND  = 22'sd2;
    localparam logic signed [SCALE_QUOT_W:0] SCALE_BIAS = 20'sd262144;

    localparam logic signed [YAW_W:0] ANGLE_HALF_TURN = 18'sd46080;
    localparam logic signed [YAW_W:0] ANGLE_FULL_TURN = 18'sd92160;

    localparam logic signed [SUM_W-1:0] SPEED_MAX = 16'sd16383;
    localparam logic signed [SUM_W-1:0] SPEED_MIN = -16'sd16384;

    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = 36'sd65535;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CRUISE_SPEED   = 3'd0,
        CFG_PROP_GAIN      = 3'd1,
        CFG_INTEG_GAIN     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_DRIVE_LIMIT    = 3'd4,
        CFG_PROFILE_STEP   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_TARGET,
        MUL_RATE,
        MUL_ERR,
        MUL_PROP,
        MUL_INTEG
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_rate;
        logic     ld_target;
        logic     ld_yaw;
        logic     ld_err;
        logic     ld_integ;
        logic     ld_pterm;
        logic     ld_acc;
        logic     ld_diff;
        logic     ld_out;
    } dp_cmd_t;

endpackage

// ===== rtl/yaw_rate_pi_with_triangle_profile_top.sv =====
`timescale 1ns / 1ps
// Each accepted word runs through the target, heading and error, integral,
//   PI sum, drive clamp and output steps; a single shared 22x22 multiplier is
//   used in five of the steps, and the sequencer runs one tick at a time.
// A finished result waits in the output register while the next word is taken.
// Reset (rst_n, asynchronous, active low) clears profile position, previous
//   target, integral and heading, and loads the register defaults.
module yaw_rate_pi_with_triangle_profile_top
    import yrpi_pkg::*;
#(
    parameter int QUARTER_TICKS = QUARTER_TICKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream: one control tick per word
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] rate_measured

    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [14:0] left_speed,
                                                  // [29:15] right_speed,
                                                  // [44:30] target_rate,
                                                  // [61:45] heading, [63:62] zero

    // Register writes: 0 cruise_speed, 1 prop_gain, 2 integ_gain,
    // 3 integral_limit, 4 drive_limit, 5 profile_step
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t cmd;

    logic signed [SPEED_W-1:0]      left_speed;
    logic signed [SPEED_W-1:0]      right_speed;
    logic signed [TARGET_OUT_W-1:0] target_rate;
    logic signed [HEAD_W-1:0]       heading;

    // Sequencer: walks each tick through target, heading, integral,
    // PI sum, drive clamp and wheel-speed steps.
    yrpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // Datapath: configuration registers, loop state, shared multiplier
    // and the result register.
    yrpi_dp #(
        .QUARTER_TICKS (QUARTER_TICKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rate_in     ($signed(s_axis_tdata[RATE_W-1:0])),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .target_rate (target_rate),
        .heading     (heading)
    );

    // Pack the result word, lowest field first, zero fill to 64 bits
    assign m_axis_tdata = {2'b00, heading, target_rate, right_speed, left_speed};

endmodule

// ===== rtl/yrpi_dp.sv =====
`timescale 1ns / 1ps
module yrpi_dp
    import yrpi_pkg::*;
#(
    parameter int QUARTER_TICKS = QUARTER_TICKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        cmd,
    input  logic signed [RATE_W-1:0]       rate_in,
    input  logic                           cfg_we,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    output logic signed [SPEED_W-1:0]      left_speed,
    output logic signed [SPEED_W-1:0]      right_speed,
    output logic signed [TARGET_OUT_W-1:0] target_rate,
    output logic signed [HEAD_W-1:0]       heading
);

    localparam int TICK_W = $clog2(4 * QUARTER_TICKS);
    localparam logic [TICK_W:0] Q1_C = (TICK_W + 1)'(QUARTER_TICKS);
    localparam logic [TICK_W:0] Q2_C = (TICK_W + 1)'(2 * QUARTER_TICKS);
    localparam logic [TICK_W:0] Q3_C = (TICK_W + 1)'(3 * QUARTER_TICKS);
    localparam logic [TICK_W:0] Q4_C = (TICK_W + 1)'(4 * QUARTER_TICKS);

    // Configuration
    logic [BASE_W-1:0] cruise_speed_reg;
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [ILIM_W-1:0] integral_limit_reg;
    logic [DLIM_W-1:0] drive_limit_reg;
    logic [STEP_W-1:0] profile_step_reg;

    // Loop state
    logic [TICK_W-1:0]          tick_reg;
    logic signed [TARGET_W-1:0] prev_target_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [YAW_W-1:0]    yaw_reg;

    // Working registers
    logic signed [RATE_W-1:0]   rate_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    pterm_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [DIFF_W-1:0]   diff_reg;

    logic signed [SPEED_W-1:0]      left_reg;
    logic signed [SPEED_W-1:0]      right_reg;
    logic signed [TARGET_OUT_W-1:0] target_out_reg;
    logic signed [HEAD_W-1:0]       heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_speed_reg   <= CRUISE_SPEED_RST;
            prop_gain_reg      <= PROP_GAIN_RST;
            integ_gain_reg     <= INTEG_GAIN_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
            drive_limit_reg    <= DRIVE_LIMIT_RST;
            profile_step_reg   <= PROFILE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CRUISE_SPEED:   cruise_speed_reg   <= cfg_wdata[BASE_W-1:0];
                CFG_PROP_GAIN:      prop_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:     integ_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata[ILIM_W-1:0];
                CFG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_wdata[DLIM_W-1:0];
                CFG_PROFILE_STEP:   profile_step_reg   <= cfg_wdata[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Profile segment decode
    logic [TICK_W:0] tick_ext;
    logic [TICK_W:0] seg_k;
    logic [TICK_W:0] tick_inc;
    logic [TICK_W-1:0] tick_next;
    logic            tgt_neg;

    always_comb
    begin
        tick_ext = {1'b0, tick_reg};
        tgt_neg  = (tick_ext >= Q2_C);
        if (tick_ext < Q1_C)
            seg_k = tick_ext;
        else if (tick_ext < Q2_C)
            seg_k = Q2_C - tick_ext;
        else if (tick_ext < Q3_C)
            seg_k = tick_ext - Q2_C;
        else
            seg_k = Q4_C - tick_ext;
        tick_inc  = tick_ext + 1'b1;
        tick_next = (tick_inc == Q4_C) ? '0 : tick_inc[TICK_W-1:0];
    end

    // Shared multiplier
    logic signed [ERR_W-1:0] sc_src;
    logic signed [MUL_W-1:0] sc_x;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        sc_src = (cmd.mul_sel == MUL_RATE) ? ERR_W'(rate_reg) : err_reg;
        sc_x   = (MUL_W'(sc_src) <<< 2) + SCALE_ROUND + SCALE_OFFSET;
        case (cmd.mul_sel)
            MUL_TARGET:
            begin
                mul_a = MUL_W'(seg_k);
                mul_b = MUL_W'(profile_step_reg);
            end
            MUL_RATE, MUL_ERR:
            begin
                mul_a = sc_x;
                mul_b = SCALE_RECIP;
            end
            MUL_PROP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(prop_gain_reg);
            end
            MUL_INTEG:
            begin
                mul_a = MUL_W'(integ_reg);
                mul_b = MUL_W'(integ_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Undo the scale offset
    logic [SCALE_QUOT_W-1:0]   sc_quot;
    logic signed [SCALE_QUOT_W:0] sc_diff;
    logic signed [SCALED_W-1:0] scaled;

    always_comb
    begin
        sc_quot = prod_reg[SCALE_SHIFT +: SCALE_QUOT_W];
        sc_diff = $signed({1'b0, sc_quot}) - SCALE_BIAS;
        scaled  = SCALED_W'(sc_diff);
    end

    // Target, sign change
    logic signed [TARGET_W-1:0] tgt_mag;
    logic signed [TARGET_W-1:0] target_next;
    logic                       sign_flip;

    always_comb
    begin
        tgt_mag     = $signed(prod_reg[TARGET_W-1:0]);
        target_next = tgt_neg ? -tgt_mag : tgt_mag;
        sign_flip   = ((target_next > 0) && (prev_target_reg < 0)) ||
                      ((target_next < 0) && (prev_target_reg > 0));
    end

    // Heading wrap
    logic signed [YAW_W:0]   yaw_sum;
    logic signed [YAW_W:0]   yaw_wrap;

    always_comb
    begin
        yaw_sum = (YAW_W + 1)'(yaw_reg) + scaled;
        if (yaw_sum > ANGLE_HALF_TURN)
            yaw_wrap = yaw_sum - ANGLE_FULL_TURN;
        else if (yaw_sum < -ANGLE_HALF_TURN)
            yaw_wrap = yaw_sum + ANGLE_FULL_TURN;
        else
            yaw_wrap = yaw_sum;
    end

    // Integral clamp
    logic signed [ISUM_W-1:0] isum;
    logic signed [ISUM_W-1:0] ilim_p;
    logic signed [ISUM_W-1:0] iclamp;

    always_comb
    begin
        isum   = ISUM_W'(integ_reg) + ISUM_W'(scaled);
        ilim_p = $signed({{(ISUM_W - ILIM_W){1'b0}}, integral_limit_reg});
        if (isum > ilim_p)
            iclamp = ilim_p;
        else if (isum < -ilim_p)
            iclamp = -ilim_p;
        else
            iclamp = isum;
    end

    // Truncate toward zero, then drive clamp
    logic signed [ACC_W-1:0] acc_adj;
    logic signed [QUO_W-1:0] quo;
    logic signed [QUO_W-1:0] dlim_p;
    logic signed [QUO_W-1:0] dclamp;

    always_comb
    begin
        acc_adj = acc_reg[ACC_W-1] ? (acc_reg + TRUNC_BIAS) : acc_reg;
        quo     = acc_adj[ACC_W-1:16];
        dlim_p  = $signed({{(QUO_W - DLIM_W){1'b0}}, drive_limit_reg});
        if (quo > dlim_p)
            dclamp = dlim_p;
        else if (quo < -dlim_p)
            dclamp = -dlim_p;
        else
            dclamp = quo;
    end

    // Wheel speeds
    logic signed [SUM_W-1:0] base_s;
    logic signed [SUM_W-1:0] diff_s;
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] right_sum;
    logic signed [SUM_W-1:0] left_sat;
    logic signed [SUM_W-1:0] right_sat;

    always_comb
    begin
        base_s    = $signed({{(SUM_W - BASE_W){1'b0}}, cruise_speed_reg});
        diff_s    = SUM_W'(diff_reg);
        left_sum  = base_s + diff_s;
        right_sum = base_s - diff_s;
        if (left_sum > SPEED_MAX)
            left_sat = SPEED_MAX;
        else if (left_sum < SPEED_MIN)
            left_sat = SPEED_MIN;
        else
            left_sat = left_sum;
        if (right_sum > SPEED_MAX)
            right_sat = SPEED_MAX;
        else if (right_sum < SPEED_MIN)
            right_sat = SPEED_MIN;
        else
            right_sat = right_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            prev_target_reg <= '0;
            integ_reg       <= '0;
            yaw_reg         <= '0;
        end
        else
        begin
            if (cmd.ld_target)
            begin
                tick_reg        <= tick_next;
                prev_target_reg <= target_next;
                if (sign_flip)
                    integ_reg <= '0;
            end
            if (cmd.ld_integ)
                integ_reg <= INTEG_W'(iclamp);
            if (cmd.ld_yaw)
                yaw_reg <= YAW_W'(yaw_wrap);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_rate)
            rate_reg <= rate_in;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.ld_target)
            target_reg <= target_next;
        if (cmd.ld_err)
            err_reg <= ERR_W'(target_reg) - ERR_W'(rate_reg);
        if (cmd.ld_pterm)
            pterm_reg <= ACC_W'(prod_reg) <<< 4;
        if (cmd.ld_acc)
            acc_reg <= pterm_reg + ACC_W'(prod_reg);
        if (cmd.ld_diff)
            diff_reg <= DIFF_W'(dclamp);
        if (cmd.ld_out)
        begin
            left_reg       <= SPEED_W'(left_sat);
            right_reg      <= SPEED_W'(right_sat);
            target_out_reg <= TARGET_OUT_W'(target_reg);
            heading_reg    <= yaw_reg;
        end
    end

    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign target_rate = target_out_reg;
    assign heading     = heading_reg;

    // Heading stays wrapped into one turn
    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (yaw_reg <= 17'sd46080) && (yaw_reg >= -17'sd46080))
        else $error("heading left the wrapped range");

endmodule

// ===== rtl/yrpi_ctrl.sv =====
`timescale 1ns / 1ps
module yrpi_ctrl
    import yrpi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_TGT_WB,
        S_ERR,
        S_ERR_MUL,
        S_INTEG,
        S_PROP,
        S_SUM,
        S_DIFF,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    always_comb
    begin
        accept   = (state_reg == S_IDLE) && in_valid;
        out_free = !out_valid_reg || out_ready;

        cmd         = '0;
        cmd.mul_sel = MUL_TARGET;
        cmd.ld_rate = accept;
        state_next  = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TARGET;
                state_next  = S_TGT_WB;
            end
            S_TGT_WB:
            begin
                cmd.ld_target = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_RATE;
                state_next    = S_ERR;
            end
            S_ERR:
            begin
                cmd.ld_yaw = 1'b1;
                cmd.ld_err = 1'b1;
                state_next = S_ERR_MUL;
            end
            S_ERR_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.ld_integ = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_PROP;
                state_next   = S_PROP;
            end
            S_PROP:
            begin
                cmd.ld_pterm = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INTEG;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.ld_acc = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.ld_diff = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // Hold here until the output word is free
                if (out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_TGT))
        else $error("accepted word did not start the sequence");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.ld_out))
        else $error("output valid rose without a result load");

endmodule

// ===== verif/yaw_rate_pi_with_triangle_profile_top_test.sv =====
`timescale 1ns / 1ps
module yaw_rate_pi_with_triangle_profile_top_test;
    import yrpi_pkg::*;

    // Register indexes past the end of the map; writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int QTR = QUARTER_TICKS_DEF;

    // One expected result word, fields as they sit in m_axis_tdata
    typedef struct {
        logic [SPEED_W-1:0]      left_speed;
        logic [SPEED_W-1:0]      right_speed;
        logic [TARGET_OUT_W-1:0] target_rate;
        logic [HEAD_W-1:0]       heading;
    } wheel_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] rate_measured
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [14:0] left_speed, [29:15] right_speed,
                                                // [44:30] target_rate, [61:45] heading
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Rates waiting to be sent, and the wheel commands they should produce
    logic [IN_DATA_W-1:0] pending_rates[$];
    wheel_cmd_t           predicted_cmds[$];

    // Rates for the directed opening, in order
    logic [IN_DATA_W-1:0] directed_rates[20] = '{
        16'd0, 16'd28800, 16'd28800, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF,
        16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
        16'd2, 16'hFFFE, 16'd3, 16'hFFFD, 16'h5555, 16'hAAAA,
        16'd10200, -16'sd10200
    };

    // Shadow of the controller registers
    logic [BASE_W-1:0] cruise_speed_reg;
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [ILIM_W-1:0] integral_limit_reg;
    logic [DLIM_W-1:0] drive_limit_reg;
    logic [STEP_W-1:0] profile_step_reg;

    // Shadow of the controller state
    int profile_pos;
    int prior_target;
    int integ_acc;
    int yaw_heading;

    int mismatch_count = 0;

    // Traffic shaping
    bit sender_gaps_on = 1'b0;
    bit sink_gaps_on   = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_request   = 0;
    bit word_taken     = 1'b0;

    yaw_rate_pi_with_triangle_profile_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Controller prediction
    // ------------------------------------------------------------------

    // rate * 0.05 s in 1/256 deg, i.e. v*4/5 rounded to nearest
    function automatic int scale_by_dt(int v);
        int n;
        int q;
        n = 4 * v + 2;
        q = n / 5;
        if ((n % 5) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the shadow controller by one tick and return the wheel command
    function automatic wheel_cmd_t run_control_tick(logic [IN_DATA_W-1:0] raw);
        int         rate;
        int         target;
        int         step;
        int         err;
        int         lim;
        int         dl;
        int         left;
        int         right;
        longint     acc;
        wheel_cmd_t cmd;

        rate = $signed(raw);
        step = int'(profile_step_reg);

        // Triangle: up, back to zero, negative, back to zero
        if (profile_pos < QTR)
            target = profile_pos * step;
        else if (profile_pos < 2 * QTR)
            target = (2 * QTR - profile_pos) * step;
        else if (profile_pos < 3 * QTR)
            target = -((profile_pos - 2 * QTR) * step);
        else
            target = -((4 * QTR - profile_pos) * step);

        profile_pos = (profile_pos + 1 >= 4 * QTR) ? 0 : profile_pos + 1;

        // Drop the integral when the target crosses over zero
        if ((target > 0 && prior_target < 0) || (target < 0 && prior_target > 0))
            integ_acc = 0;
        prior_target = target;

        yaw_heading += scale_by_dt(rate);
        if (yaw_heading > int'(ANGLE_HALF_TURN))
            yaw_heading -= int'(ANGLE_FULL_TURN);
        else if (yaw_heading < -int'(ANGLE_HALF_TURN))
            yaw_heading += int'(ANGLE_FULL_TURN);

        err = target - rate;
        lim = int'(integral_limit_reg);
        integ_acc = clamp_int(integ_acc + scale_by_dt(err), -lim, lim);

        acc = longint'(16) * longint'(int'(prop_gain_reg)) * longint'(err)
            + longint'(int'(integ_gain_reg)) * longint'(integ_acc);
        acc = acc / 65536;
        dl = int'(drive_limit_reg);
        if (acc > dl)
            acc = dl;
        if (acc < -dl)
            acc = -dl;

        left  = clamp_int(int'(cruise_speed_reg) + int'(acc),
                          int'(SPEED_MIN), int'(SPEED_MAX));
        right = clamp_int(int'(cruise_speed_reg) - int'(acc),
                          int'(SPEED_MIN), int'(SPEED_MAX));

        cmd.left_speed  = left[SPEED_W-1:0];
        cmd.right_speed = right[SPEED_W-1:0];
        cmd.target_rate = target[TARGET_OUT_W-1:0];
        cmd.heading     = yaw_heading[HEAD_W-1:0];
        return cmd;
    endfunction

    function automatic void report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly plausible rates around the profile, some full range noise and rails
    function automatic logic [IN_DATA_W-1:0] random_rate();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 4095)) - 2048;
            6, 7:             v = int'($urandom_range(0, 20400)) - 10200;
            8:                v = $urandom;
            default:          v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        return v[IN_DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer one rate word per tick, hold it until taken
    // ------------------------------------------------------------------

    // Note each accepted word and predict its result at the same edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predicted_cmds.push_back(run_control_tick(s_axis_tdata));
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!s_axis_tvalid || word_taken)
        begin
            word_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_rates.size() != 0)
            begin
                s_axis_tdata  <= pending_rates.pop_front();
                s_axis_tvalid <= 1'b1;
                if (sender_gaps_on && $urandom_range(0, 2) == 0)
                    send_gap = pick_gap_length();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_gaps_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap_length();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        wheel_cmd_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_cmds.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with nothing predicted",
                                          m_axis_tdata));
            end
            else
            begin
                want = predicted_cmds.pop_front();
                if (m_axis_tdata[14:0]  !== want.left_speed  ||
                    m_axis_tdata[29:15] !== want.right_speed ||
                    m_axis_tdata[44:30] !== want.target_rate ||
                    m_axis_tdata[61:45] !== want.heading)
                    report_mismatch($sformatf(
                        "left %0d/%0d right %0d/%0d target %0d/%0d heading %0d/%0d (exp/got)",
                        $signed(want.left_speed),  $signed(m_axis_tdata[14:0]),
                        $signed(want.right_speed), $signed(m_axis_tdata[29:15]),
                        $signed(want.target_rate), $signed(m_axis_tdata[44:30]),
                        $signed(want.heading),     $signed(m_axis_tdata[61:45])));
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration and phase sequencing
    // ------------------------------------------------------------------

    // Drive one register write at the next falling edge and mirror it
    task automatic program_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_CRUISE_SPEED:   cruise_speed_reg   = value[BASE_W-1:0];
            CFG_PROP_GAIN:      prop_gain_reg      = value[GAIN_W-1:0];
            CFG_INTEG_GAIN:     integ_gain_reg     = value[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: integral_limit_reg = value[ILIM_W-1:0];
            CFG_DRIVE_LIMIT:    drive_limit_reg    = value[DLIM_W-1:0];
            CFG_PROFILE_STEP:   profile_step_reg   = value[STEP_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic apply_settings(int base, int kp, int ki, int ilim, int dlim, int step);
        program_register(CFG_CRUISE_SPEED, base[CFG_DATA_W-1:0]);
        program_register(CFG_PROP_GAIN, kp[CFG_DATA_W-1:0]);
        program_register(CFG_INTEG_GAIN, ki[CFG_DATA_W-1:0]);
        program_register(CFG_INTEGRAL_LIMIT, ilim[CFG_DATA_W-1:0]);
        program_register(CFG_DRIVE_LIMIT, dlim[CFG_DATA_W-1:0]);
        program_register(CFG_PROFILE_STEP, step[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every word is sent and answered, then let the pipeline settle
    task automatic drain_pipeline();
        while (pending_rates.size() != 0 || s_axis_tvalid || predicted_cmds.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic queue_random_rates(int count);
        repeat (count) pending_rates.push_back(random_rate());
    endtask

    initial
    begin
        cruise_speed_reg   = CRUISE_SPEED_RST;
        prop_gain_reg      = PROP_GAIN_RST;
        integ_gain_reg     = INTEG_GAIN_RST;
        integral_limit_reg = INTEGRAL_LIMIT_RST;
        drive_limit_reg    = DRIVE_LIMIT_RST;
        profile_step_reg   = PROFILE_STEP_RST;
        profile_pos  = 0;
        prior_target = 0;
        integ_acc    = 0;
        yaw_heading  = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset defaults, no idling. Walk the heading onto exactly
        // +180 deg (no wrap), just past it (wrap), then exactly -180 deg and just
        // past it likewise, then the rails of the rate field and small rounding cases.
        foreach (directed_rates[i])
            pending_rates.push_back(directed_rates[i]);
        drain_pipeline();

        // Random ticks with idling on both sides; stall the receiver long
        // enough that the block backs up and drops its input ready
        sender_gaps_on = 1'b1;
        sink_gaps_on   = 1'b1;
        hold_request   = 300;
        queue_random_rates(300);
        drain_pipeline();

        // Every register at the top of its field (wider than the stated
        // ranges, so the wheel speed saturates); spare indexes must do nothing
        apply_settings(32767, 32767, 32767, 32767, 32767, 32767);
        program_register(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        program_register(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        sender_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        queue_random_rates(300);
        drain_pipeline();

        // Every register at zero: flat profile, no drive, integral pinned
        apply_settings(0, 0, 0, 0, 0, 0);
        sender_gaps_on = 1'b1;
        sink_gaps_on   = 1'b0;
        queue_random_rates(200);
        drain_pipeline();

        // Upper ends of the stated ranges
        apply_settings(10000, 4095, 4095, 32767, 5000, 255);
        sender_gaps_on = 1'b0;
        sink_gaps_on   = 1'b1;
        queue_random_rates(200);
        drain_pipeline();

        // Random settings within the stated ranges
        repeat (4)
        begin
            apply_settings($urandom_range(0, 10000), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 32767),
                           $urandom_range(0, 5000), $urandom_range(0, 255));
            sender_gaps_on = $urandom_range(0, 1);
            sink_gaps_on   = $urandom_range(0, 1);
            queue_random_rates(250);
            drain_pipeline();
        end

        if (mismatch_count == 0 && predicted_cmds.size() == 0)
            $display("yaw_rate_pi_with_triangle_profile_top_test passed");
        else
            $display("yaw_rate_pi_with_triangle_profile_top_test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("yaw_rate_pi_with_triangle_profile_top_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/yrpi_pkg.sv
rtl/yrpi_dp.sv
rtl/yrpi_ctrl.sv
rtl/yaw_rate_pi_with_triangle_profile_top.sv
verif/yaw_rate_pi_with_triangle_profile_top_test.sv
